@@ rtl/core/dtq_pkg.sv @@
// shared types and constants for the drop-tail timestamp queue
package dtq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CAP_W         = 7;
    localparam int STAMP_W       = 32;
    localparam int TOTAL_W       = 32;
    localparam int OCC_W         = 7;
    localparam int STATUS_W      = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_AVAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    typedef enum logic
    {
        OP_RECEIVE = 1'b0,
        OP_CONSUME = 1'b1
    } op_t;

    // per-cell controls
    typedef struct packed
    {
        logic shift;
        logic write;
    } cell_ctl_t;

    typedef struct packed
    {
        logic [TOTAL_W-1:0]  consumed_total;
        logic [TOTAL_W-1:0]  received_total;
        logic [TOTAL_W-1:0]  dropped_total;
        logic                latency_valid;
        logic [STAMP_W-1:0]  latency;
        logic [OCC_W-1:0]    occupancy;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

@@ rtl/core/dtq_cell.sv @@
// one storage cell of the timestamp chain
module dtq_cell
(
    input  logic                        clk,
    input  dtq_pkg::cell_ctl_t          ctl,
    input  logic [dtq_pkg::STAMP_W-1:0] stamp_in,
    input  logic [dtq_pkg::STAMP_W-1:0] neighbor,
    output logic [dtq_pkg::STAMP_W-1:0] stamp
);
    import dtq_pkg::*;

    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;

    // shift toward the head on consume, load at the tail on receive
    always_comb
    begin
        stamp_next = stamp_reg;
        if (ctl.shift)
        begin
            stamp_next = neighbor;
        end
        else if (ctl.write)
        begin
            stamp_next = stamp_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

    assign stamp = stamp_reg;

endmodule

@@ rtl/core/dtq_ctrl.sv @@
// occupancy, capacity, saturating counters and result assembly
module dtq_ctrl
#(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  dtq_pkg::op_t                op,
    input  logic [dtq_pkg::STAMP_W-1:0] time_now,
    input  logic [dtq_pkg::STAMP_W-1:0] head_stamp,
    input  logic                        cfg_we,
    input  logic [dtq_pkg::CAP_W-1:0]   cfg_data,
    output logic                        cell_shift,
    output logic                        cell_write,
    output logic [CNT_W-1:0]            count,
    output dtq_pkg::result_t            res
);
    import dtq_pkg::*;

    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_MAX = (1 << CAP_W) - 1;
    localparam int CAP_RST = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CAP_W-1:0]   cap_reg,      cap_next;
    logic [TOTAL_W-1:0] drop_reg,     drop_next;
    logic [TOTAL_W-1:0] recv_reg,     recv_next;
    logic [TOTAL_W-1:0] cons_reg,     cons_next;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic               nonempty;

    // zero acts as one, anything past the cell count acts as the cell count
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            cap_eff = CMP_W'(DEPTH);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign full     = (CMP_W'(count_reg) >= cap_eff);
    assign nonempty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        recv_next  = recv_reg;
        cons_next  = cons_reg;
        cell_shift = 1'b0;
        cell_write = 1'b0;
        res        = '0;

        unique case (op)
            OP_RECEIVE:
            begin
                if (full)
                begin
                    drop_next  = (drop_reg == '1) ? drop_reg : drop_reg + TOTAL_W'(1);
                    res.status = ST_DROP;
                end
                else
                begin
                    cell_write = accept;
                    count_next = count_reg + CNT_W'(1);
                    recv_next  = (recv_reg == '1) ? recv_reg : recv_reg + TOTAL_W'(1);
                    res.status = nonempty ? ST_AVAIL : ST_EMPTY;
                end
            end
            OP_CONSUME:
            begin
                if (nonempty)
                begin
                    cell_shift        = accept;
                    count_next        = count_reg - CNT_W'(1);
                    cons_next         = (cons_reg == '1) ? cons_reg : cons_reg + TOTAL_W'(1);
                    res.latency       = time_now - head_stamp;
                    res.latency_valid = 1'b1;
                end
                res.status = (count_next != '0) ? ST_AVAIL : ST_EMPTY;
            end
            default:
            begin
                res.status = ST_EMPTY;
            end
        endcase

        res.occupancy      = OCC_W'(count_next);
        res.dropped_total  = drop_next;
        res.received_total = recv_next;
        res.consumed_total = cons_next;
    end

    assign cap_next = cfg_we ? cfg_data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_W'(CAP_RST);
            drop_reg  <= '0;
            recv_reg  <= '0;
            cons_reg  <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
            if (accept)
            begin
                count_reg <= count_next;
                drop_reg  <= drop_next;
                recv_reg  <= recv_next;
                cons_reg  <= cons_next;
            end
        end
    end

    assign count = count_reg;

endmodule

@@ rtl/core/drop_tail_timestamp_queue_unit.sv @@
// top level of the drop-tail timestamp queue: cell chain, control and output register
//
// A bounded drop-tail queue of packet arrival times. Each input word is either a
// receive (s_tuser = 0), which stores time_now at the tail, or a consume (s_tuser = 1),
// which removes the head and reports time_now minus its arrival time, modulo 2^32.
// A receive into a queue holding at least the capacity is dropped and counted.
// Storage is a chain of DEPTH cells with the head always in the first cell: a receive
// loads the cell at the current occupancy, a consume moves every cell one place toward
// the head together. One input word is taken per cycle and its result appears on the
// master side in the next cycle, held in an output register. s_tready is low only while
// that register holds a result that m_tready has not yet taken, so the sustained rate
// is one word per cycle under no backpressure. Capacity is written on the cfg channel
// (always ready, 0 acts as 1, values above DEPTH act as DEPTH) and resets to DEPTH,
// capped at 127; write it only while no word is in flight. Counters saturate at 2^32-1.
module drop_tail_timestamp_queue_unit
#(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // slave side
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,   // time_now[31:0]
    input  logic                      s_tuser,   // operation
    // master side
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [143:0]              m_tdata,   // status[1:0], occupancy[8:2],
                                                 // latency[40:9], dropped_total[72:41],
                                                 // received_total[104:73],
                                                 // consumed_total[136:105], zero pad
    output logic                      m_tuser,   // latency_valid
    // capacity write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dtq_pkg::CAP_W-1:0] cfg_data
);
    import dtq_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RES_W  = $bits(result_t);
    localparam int TDATA_W = 144;

    logic               accept;
    logic               cell_shift;
    logic               cell_write;
    logic [CNT_W-1:0]   count;
    result_t            res;
    result_t            res_reg;
    logic               out_valid_reg, out_valid_next;
    logic [STAMP_W-1:0] stamps [DEPTH];

    // input taken whenever the output register is free or being drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    dtq_ctrl
    #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    )
    u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op_t'(s_tuser)),
        .time_now   (s_tdata),
        .head_stamp (stamps[0]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .cell_shift (cell_shift),
        .cell_write (cell_write),
        .count      (count),
        .res        (res)
    );

    // cell chain, head in cell 0, each cell pulls from the next on a consume
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctl_t          ctl;
        logic [STAMP_W-1:0] neighbor;

        assign ctl.shift = cell_shift;
        assign ctl.write = cell_write && (count == CNT_W'(i));

        if (i == DEPTH - 1)
        begin : g_last
            assign neighbor = '0;
        end
        else
        begin : g_mid
            assign neighbor = stamps[i+1];
        end

        dtq_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .stamp_in (s_tdata),
            .neighbor (neighbor),
            .stamp    (stamps[i])
        );
    end

    // output register
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.latency_valid;
    assign m_tdata  = TDATA_W'({res_reg.consumed_total,
                                res_reg.received_total,
                                res_reg.dropped_total,
                                res_reg.latency,
                                res_reg.occupancy,
                                res_reg.status});

    // RES_W counts the latency_valid bit, which travels on m_tuser instead
    if (RES_W - 1 > TDATA_W)
    begin : g_width_error
        $error("result does not fit m_tdata");
    end

endmodule

@@ tb/sv/drop_tail_unit_test.sv @@
// self-checking testbench for the drop-tail timestamp queue unit
module drop_tail_timestamp_queue_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 96;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 80;
    localparam int QUIET_WORDS = 150;

    // predicts the queue's result for every accepted word and checks it against the dut
    class queue_result_book;
        logic [STAMP_W-1:0] arrival_stamps [QUEUE_DEPTH];
        logic [5:0]         head_slot;
        logic [OCC_W-1:0]   held;
        logic [CAP_W-1:0]   capacity;
        logic [TOTAL_W-1:0] drops;
        logic [TOTAL_W-1:0] arrivals;
        logic [TOTAL_W-1:0] departures;
        result_t            pending_results[$];
        int                 errors;
        int                 words_noted;
        int                 drops_seen;
        int                 latencies_seen;
        int                 results_checked;

        function new();
            head_slot       = '0;
            held            = '0;
            capacity        = CAP_W'(QUEUE_DEPTH);
            drops           = '0;
            arrivals        = '0;
            departures      = '0;
            errors          = 0;
            words_noted     = 0;
            drops_seen      = 0;
            latencies_seen  = 0;
            results_checked = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] count);
            return (count == '1) ? count : count + 1'b1;
        endfunction

        // capacity 0 acts as 1, anything above the depth acts as the depth
        function int unsigned usable_capacity();
            if (capacity == 0)
                return 1;
            if (capacity > QUEUE_DEPTH)
                return QUEUE_DEPTH;
            return capacity;
        endfunction

        function void note_word(op_t op, logic [STAMP_W-1:0] stamp);
            result_t    want;
            logic [5:0] tail_slot;
            want = '0;
            if (op == OP_RECEIVE)
            begin
                if (held >= usable_capacity())
                begin
                    drops = bump(drops);
                    want.status = ST_DROP;
                    drops_seen++;
                end
                else
                begin
                    tail_slot = head_slot + held[5:0];
                    arrival_stamps[tail_slot] = stamp;
                    want.status = (held == 0) ? ST_EMPTY : ST_AVAIL;
                    held++;
                    arrivals = bump(arrivals);
                end
            end
            else
            begin
                // consume from an empty queue leaves everything alone
                if (held != 0)
                begin
                    want.latency       = stamp - arrival_stamps[head_slot];
                    want.latency_valid = 1'b1;
                    head_slot++;
                    held--;
                    departures = bump(departures);
                    latencies_seen++;
                end
                want.status = (held == 0) ? ST_EMPTY : ST_AVAIL;
            end
            want.occupancy      = held;
            want.dropped_total  = drops;
            want.received_total = arrivals;
            want.consumed_total = departures;
            pending_results.push_back(want);
            words_noted++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [143:0] data, logic user);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: 0x%0h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            check_field("status", 32'(want.status), 32'(data[1:0]));
            check_field("occupancy", 32'(want.occupancy), 32'(data[8:2]));
            check_field("latency", want.latency, data[40:9]);
            check_field("latency_valid", 32'(want.latency_valid), 32'(user));
            check_field("dropped_total", want.dropped_total, data[72:41]);
            check_field("received_total", want.received_total, data[104:73]);
            check_field("consumed_total", want.consumed_total, data[136:105]);
            check_field("pad", 32'd0, 32'(data[143:137]));
        endfunction

        function void check_drained();
            if (pending_results.size() != 0)
            begin
                $error("%0d result words never arrived", pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;    // time_now[31:0]
    logic               s_tuser;    // operation
    logic               m_tvalid;
    logic               m_tready;
    logic [143:0]       m_tdata;    // status, occupancy, latency, dropped, received,
                                    // consumed totals, zero pad
    logic               m_tuser;    // latency_valid
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;

    queue_result_book   book = new();

    // knobs shared between the word source and the result sink
    bit                 source_gaps;
    bit                 sink_gaps;
    bit                 gaps_off;
    bit                 hold_request;
    int                 cycles;
    logic [31:0]        tick;

    drop_tail_timestamp_queue_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // offer one word and hold it until the queue takes it; the caller sits on a rising edge
    task automatic send_word(op_t op, logic [31:0] stamp);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stamp;
        do
            @(posedge clk);
        while (!s_tready);
        book.note_word(op, stamp);
    endtask

    // stop offering and wait until every result is back; the extra edges cover
    // the output register before a capacity write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.set_capacity(value);
    endtask

    // mostly a slowly advancing clock, now and then a jump anywhere in the 32-bit range
    function automatic logic [31:0] next_stamp();
        if ($urandom_range(0, 7) == 0)
            tick = $urandom();
        else
            tick = tick + $urandom_range(0, 40);
        return tick;
    endfunction

    // result sink: random stall bursts, one long hold on request, none at the tail
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                book.check_word(m_tdata, m_tuser);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !gaps_off && sink_gaps && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : word_source
        int         bias;
        int         gap;
        int         phase;
        int         n;
        op_t        op;
        logic [6:0] caps [PHASES];

        source_gaps  = 1'b1;
        sink_gaps    = 1'b1;
        gaps_off     = 1'b0;
        hold_request = 1'b0;
        tick         = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset capacity, empty consumes, stamp extremes, wrapping latency
        send_word(OP_CONSUME, 32'h0000_0000);
        send_word(OP_CONSUME, 32'hFFFF_FFFF);
        send_word(OP_RECEIVE, 32'h0000_0000);
        send_word(OP_RECEIVE, 32'hFFFF_FFFF);
        send_word(OP_RECEIVE, 32'h8000_0000);
        send_word(OP_CONSUME, 32'hFFFF_FFFF);
        send_word(OP_CONSUME, 32'h0000_0005);
        send_word(OP_CONSUME, 32'h8000_0000);
        send_word(OP_CONSUME, 32'h1234_5678);

        // one-entry queue: first receive reports was-empty, the rest drop
        write_capacity(7'd1);
        send_word(OP_RECEIVE, 32'h0000_0010);
        send_word(OP_RECEIVE, 32'h0000_0011);
        send_word(OP_CONSUME, 32'h0000_0020);

        // zero acts as one
        write_capacity(7'd0);
        send_word(OP_RECEIVE, 32'h5555_5555);
        send_word(OP_RECEIVE, 32'hAAAA_AAAA);
        send_word(OP_CONSUME, 32'hAAAA_AAAA);

        // above the depth acts as the depth; then shrink below the current fill
        write_capacity(7'd127);
        for (n = 0; n < 5; n++)
            send_word(OP_RECEIVE, 32'h100 + n);
        write_capacity(7'd2);
        send_word(OP_RECEIVE, 32'h200);
        send_word(OP_CONSUME, 32'h300);
        send_word(OP_RECEIVE, 32'h301);
        send_word(OP_CONSUME, 32'h302);
        send_word(OP_CONSUME, 32'h303);
        send_word(OP_CONSUME, 32'h304);
        send_word(OP_RECEIVE, 32'h305);

        // random phases; capacity changes land on whatever fill the last phase left
        caps = '{7'd127, 7'd64, 7'd3, 7'd65, 7'd1, 7'd0, 7'd40, 7'd64,
                 7'd8, 7'd127, 7'd2, 7'd64};
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 2 || phase == 6)
                write_capacity(7'($urandom_range(0, 127)));
            write_capacity(caps[phase]);
            case (phase % 4)
                0: bias = 85;
                1: bias = 50;
                2: bias = 30;
                default: bias = 65;
            endcase
            source_gaps = (phase % 3) != 1;
            sink_gaps   = (phase % 5) != 3;
            // long receiver hold while the source keeps offering
            if (phase == 4)
            begin
                source_gaps  = 1'b0;
                hold_request = 1'b1;
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                op = ($urandom_range(0, 99) < bias) ? OP_RECEIVE : OP_CONSUME;
                send_word(op, next_stamp());
                if (!gaps_off && source_gaps && $urandom_range(0, 5) == 0)
                begin
                    gap = $urandom_range(1, 11);
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        // back-to-back tail with no idling on either side
        gaps_off = 1'b1;
        for (n = 0; n < QUIET_WORDS; n++)
        begin
            op = ($urandom_range(0, 1) == 0) ? OP_RECEIVE : OP_CONSUME;
            send_word(op, next_stamp());
        end

        settle();
        repeat (8) @(posedge clk);
        book.check_drained();
        $display("covered %0d words over %0d capacity settings in %0d cycles",
                 book.words_noted, PHASES + 6, cycles);
        $display("%0d drops and %0d timed departures checked",
                 book.drops_seen, book.latencies_seen);
        if (book.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ drop_tail_timestamp_queue_unit.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_cell.sv
rtl/core/dtq_ctrl.sv
rtl/core/drop_tail_timestamp_queue_unit.sv
tb/sv/drop_tail_unit_test.sv
